// File: hw/rtl/bbf_pkg.sv
// ----------------------------------------------------------------------------
// bbf_pkg
// shared types and constants of the box blur filter
// ----------------------------------------------------------------------------
package bbf_pkg;

  localparam int POS_W      = 26;
  localparam int DIM_W      = 13;
  localparam int KER_W      = 3;
  localparam int SUM_W      = 14;
  localparam int RECIP_W    = 25;
  localparam int RECIP_SH   = 24;
  localparam int ROW_LIMIT  = 4096;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KERNEL = 2'd2;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic take;
    logic start;
    logic tap;
    logic mul;
    logic load;
  } bbf_ctl_t;

  typedef struct packed {
    logic emit;
    logic tap_last;
    logic out_free;
    logic settle;
  } bbf_sts_t;

  // reciprocal of k*k scaled by 2^24, rounded up
  function automatic logic [RECIP_W-1:0] recip(input logic [KER_W-1:0] k);
    logic [RECIP_W-1:0] m;
    unique case (k)
      3'd3:    m = RECIP_W'((2**RECIP_SH + 8) / 9);
      3'd5:    m = RECIP_W'((2**RECIP_SH + 24) / 25);
      3'd7:    m = RECIP_W'((2**RECIP_SH + 48) / 49);
      default: m = RECIP_W'(2**RECIP_SH);
    endcase
    return m;
  endfunction

endpackage

// File: hw/rtl/bbf_if.sv
// ----------------------------------------------------------------------------
// bbf_if
// stream channels of the box blur filter
// ----------------------------------------------------------------------------
interface bbf_pix_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] pixel_value;
  modport source (output valid, command, pixel_value, input ready);
  modport sink   (input valid, command, pixel_value, output ready);
endinterface

interface bbf_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] blurred_value;
  logic       frame_end;
  modport source (output valid, blurred_value, frame_end, input ready);
  modport sink   (input valid, blurred_value, frame_end, output ready);
endinterface

// File: hw/rtl/bbf_ram.sv
// ----------------------------------------------------------------------------
// bbf_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/bbf_ctrl.sv
// ----------------------------------------------------------------------------
// bbf_ctrl
// sequencer of the box blur filter: accept, tap sweep, scale, deliver
// ----------------------------------------------------------------------------
module bbf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bbf_pkg::bbf_sts_t sts,
  output bbf_pkg::bbf_ctl_t ctl
);
  import bbf_pkg::*;

  typedef enum logic [2:0] {IDLE, TAP, DRAIN, MUL, FIN} state_t;
  state_t state;

  assign in_ready  = (state == IDLE) && !sts.settle;
  assign ctl.take  = in_ready && in_valid;
  assign ctl.start = ctl.take && sts.emit;
  assign ctl.tap   = (state == TAP);
  assign ctl.mul   = (state == MUL);
  assign ctl.load  = (state == FIN) && sts.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE:  if (ctl.start) state <= TAP;
        TAP:   if (sts.tap_last) state <= DRAIN;
        DRAIN: state <= MUL;
        MUL:   state <= FIN;
        FIN:   if (sts.out_free) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// File: hw/rtl/bbf_dpath.sv
// ----------------------------------------------------------------------------
// bbf_dpath
// datapath: settings, position counters, line store, window sum, scaling
// ----------------------------------------------------------------------------
module bbf_dpath #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_KERNEL = 7,
  parameter int DEPTH      = 32768
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [bbf_pkg::DIM_W-1:0]    cfg_data,
  input  logic                         command,
  input  logic [7:0]                   pixel_value,
  input  bbf_pkg::bbf_ctl_t            ctl,
  output bbf_pkg::bbf_sts_t            sts,
  bbf_res_if.source                    res
);
  import bbf_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [DIM_W-1:0] cfg_w, cfg_h;
  logic [KER_W-1:0] cfg_k;
  logic             settle;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [KER_W-1:0] k_eff;
  logic [1:0]       rad;
  logic [POS_W-1:0] total, lag;

  logic [POS_W-1:0] in_pos, out_pos;
  logic [DIM_W-1:0] out_row, out_col;
  logic             in_range, restart, last;

  logic [KER_W-1:0]   dx, dy;
  logic signed [13:0] row_i, col_i, col_start;
  logic [AW-1:0]      row_addr, rd_addr;
  logic               pend, tap_ok_q, tap_ok;
  logic [7:0]         ram_q;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W+RECIP_W-1:0] prod;

  // effective settings
  always_comb begin
    w_eff = cfg_w;
    if (w_eff == '0) w_eff = DIM_W'(1);
    if ({1'b0, w_eff} > (DIM_W+1)'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
    h_eff = cfg_h;
    if (h_eff == '0) h_eff = DIM_W'(1);
    if (h_eff > DIM_W'(ROW_LIMIT)) h_eff = DIM_W'(ROW_LIMIT);
    k_eff = cfg_k;
    if ({1'b0, k_eff} > (KER_W+1)'(MAX_KERNEL)) k_eff = KER_W'(MAX_KERNEL);
    if (k_eff == '0) k_eff = KER_W'(1);
    if (!k_eff[0]) k_eff = k_eff - KER_W'(1);
  end
  assign rad = k_eff[2:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w  <= DIM_W'(640);
      cfg_h  <= DIM_W'(480);
      cfg_k  <= KER_W'(3);
      settle <= 1'b1;
    end else begin
      settle <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WIDTH:  cfg_w <= cfg_data;
          REG_HEIGHT: cfg_h <= cfg_data;
          REG_KERNEL: cfg_k <= cfg_data[KER_W-1:0];
          default: ;
        endcase
      end
    end
    total <= POS_W'(w_eff) * POS_W'(h_eff);
    lag   <= POS_W'(w_eff) * POS_W'(rad) + POS_W'(rad);
  end

  assign in_range = in_pos < total;
  assign last     = (out_pos + POS_W'(1)) >= total;
  assign restart  = (cfg_we && cfg_index != REG_UNUSED) || (ctl.load && last);

  assign sts.emit     = !(in_range && command == CMD_FLUSH) && (in_pos >= lag);
  assign sts.tap_last = (dx == k_eff - KER_W'(1)) && (dy == k_eff - KER_W'(1));
  assign sts.out_free = !res.valid || res.ready;
  assign sts.settle   = settle;

  // position counters
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_pos  <= '0;
      out_pos <= '0;
      out_row <= '0;
      out_col <= '0;
    end else begin
      if (ctl.take && !(in_range && command == CMD_FLUSH)) begin
        in_pos <= in_pos + POS_W'(1);
      end
      if (ctl.load) begin
        out_pos <= out_pos + POS_W'(1);
        if (out_col + DIM_W'(1) >= w_eff) begin
          out_col <= '0;
          out_row <= out_row + DIM_W'(1);
        end else begin
          out_col <= out_col + DIM_W'(1);
        end
      end
    end
  end

  bbf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ctl.take && in_range && command != CMD_FLUSH),
    .waddr (in_pos[AW-1:0]),
    .wdata (pixel_value),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // window sweep, one tap per cycle
  assign col_start = $signed({1'b0, out_col}) - $signed({12'd0, rad});
  assign tap_ok = !row_i[13] && (row_i[12:0] < h_eff) &&
                  !col_i[13] && (col_i[12:0] < w_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= ctl.tap;
    end
    tap_ok_q <= tap_ok;
    if (ctl.start) begin
      dx       <= '0;
      dy       <= '0;
      row_i    <= $signed({1'b0, out_row}) - $signed({12'd0, rad});
      col_i    <= col_start;
      row_addr <= out_pos[AW-1:0] - lag[AW-1:0];
      rd_addr  <= out_pos[AW-1:0] - lag[AW-1:0];
      sum      <= '0;
    end else begin
      if (ctl.tap) begin
        if (dx == k_eff - KER_W'(1)) begin
          dx       <= '0;
          dy       <= dy + KER_W'(1);
          row_i    <= row_i + 14'sd1;
          col_i    <= col_start;
          row_addr <= row_addr + AW'(w_eff);
          rd_addr  <= row_addr + AW'(w_eff);
        end else begin
          dx      <= dx + KER_W'(1);
          col_i   <= col_i + 14'sd1;
          rd_addr <= rd_addr + AW'(1);
        end
      end
      if (pend && tap_ok_q) begin
        sum <= sum + SUM_W'(ram_q);
      end
    end
    if (ctl.mul) begin
      prod <= sum * recip(k_eff);
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (ctl.load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
    if (ctl.load) begin
      res.blurred_value <= prod[RECIP_SH +: 8];
      res.frame_end     <= last;
    end
  end
endmodule

// File: hw/rtl/box_blur_filter_unit.sv
// ----------------------------------------------------------------------------
// box_blur_filter_unit
// streaming mean blur of an 8-bit grayscale frame
// ----------------------------------------------------------------------------
//   channel   dir  word
//   pixels    in   command, pixel_value
//   results   out  blurred_value, frame_end
//   cfg       in   cfg_we, cfg_index, cfg_data
//
// an item with no result is taken while idle; one with a result starts a
// one-tap-per-cycle sweep over the line store read port, and no new item is
// taken until its result is loaded; a configuration write holds off input in the cycle after it
// reset is synchronous; the line store needs no clearing
// a stalled result holds in the output register, input waits until it frees
// ----------------------------------------------------------------------------
module box_blur_filter_unit #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_KERNEL = 7
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [bbf_pkg::DIM_W-1:0] cfg_data,
  bbf_pix_if.sink                   pixels,
  bbf_res_if.source                 results
);
  import bbf_pkg::*;

  localparam int DEPTH = 2 ** $clog2((MAX_KERNEL - 1) * MAX_WIDTH + MAX_KERNEL);

  bbf_ctl_t ctl;
  bbf_sts_t sts;

  bbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixels.valid),
    .in_ready (pixels.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  bbf_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_KERNEL (MAX_KERNEL),
    .DEPTH      (DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .command     (pixels.command),
    .pixel_value (pixels.pixel_value),
    .ctl         (ctl),
    .sts         (sts),
    .res         (results)
  );

  a_tap_not_ready: assert property (@(posedge clk) disable iff (rst)
    !(ctl.tap && pixels.ready)) else $error("tap sweep while accepting input");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> sts.out_free) else $error("result loaded over a held word");

  a_start_sweep: assert property (@(posedge clk) disable iff (rst)
    ctl.start |=> ctl.tap) else $error("accepted item did not start a sweep");
endmodule

// File: verif/bbf_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbf_tb_if
// testbench-side view of the box blur filter stream channels
// ----------------------------------------------------------------------------
// the channel interfaces themselves come from the rtl interface file;
// this file only holds the item types the testbench queues use
package bbf_tb_pkg;

  typedef struct packed {
    logic       command;
    logic [7:0] pixel_value;
  } pix_word_t;

  typedef struct packed {
    logic [7:0] blurred_value;
    logic       frame_end;
  } blur_word_t;

endpackage

// File: verif/tb_box_blur_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_blur_filter_unit
// self-checking testbench of the streaming box blur filter
// ----------------------------------------------------------------------------
// frames of many sizes and kernel settings are streamed in raster order with
// flush words, noise and cut-short frames; a predictor computes every
// blurred pixel on acceptance and the monitor checks each result word in
// order, with random idling on both channels and one long receiver hold
// ----------------------------------------------------------------------------
module tb_box_blur_filter_unit;
  import bbf_pkg::*;
  import bbf_tb_pkg::*;

  localparam int MAXW        = 4096;
  localparam int MAXK        = 7;
  localparam int STORE_DEPTH = (MAXK - 1) * MAXW + MAXK;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE      = 80;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  logic [DIM_W-1:0]    cfg_data;

  bbf_pix_if pix ();
  bbf_res_if res ();

  box_blur_filter_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pix),
    .results   (res)
  );

  // predictor state
  logic [7:0]  line_mem [0:STORE_DEPTH-1];
  int unsigned row_in, col_in, row_out, col_out;
  int unsigned reg_w, reg_h, reg_k;

  pix_word_t   pending_q [$];
  blur_word_t  blur_q [$];
  int          errors;
  int          items_added;
  bit          calm;
  int          hold_gen;
  int          hold_seen;
  int          hold_cnt;
  bit          took;
  bit          in_took;
  int          quiet;

  always #4 clk = ~clk;

  function automatic int unsigned eff_w();
    int unsigned w;
    w = reg_w & 13'h1fff;
    if (w == 0) w = 1;
    if (w > MAXW) w = MAXW;
    return w;
  endfunction

  function automatic int unsigned eff_h();
    int unsigned h;
    h = reg_h & 13'h1fff;
    if (h == 0) h = 1;
    if (h > ROW_LIMIT) h = ROW_LIMIT;
    return h;
  endfunction

  function automatic int unsigned eff_k();
    int unsigned k;
    k = reg_k & 3'h7;
    if (k > MAXK) k = MAXK;
    if (k == 0) k = 1;
    if ((k & 1) == 0) k = k - 1;
    return k;
  endfunction

  function automatic void blur_config(input logic [1:0] idx, input logic [DIM_W-1:0] val);
    if (idx == REG_WIDTH) reg_w = val;
    else if (idx == REG_HEIGHT) reg_h = val;
    else if (idx == REG_KERNEL) reg_k = val & 3'h7;
    else return;
    row_in = 0; col_in = 0; row_out = 0; col_out = 0;
  endfunction

  function automatic bit blur_step(input pix_word_t wd, output blur_word_t rw);
    int unsigned w, h, k, rad, total, lag, pos, sum, tr, tc;
    bit last;
    w = eff_w(); h = eff_h(); k = eff_k();
    rad = (k - 1) / 2;
    total = w * h;
    lag = rad * w + rad;
    rw = '0;
    if (col_in >= w) col_in = 0;
    pos = row_in * w + col_in;
    if (pos < total) begin
      if (wd.command == CMD_FLUSH) return 0;
      line_mem[pos % STORE_DEPTH] = wd.pixel_value;
    end
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
    end
    if (pos < lag) return 0;
    sum = 0;
    for (int dy = 0; dy < k; dy++) begin
      tr = row_out + dy;
      if (tr < rad || tr - rad >= h) continue;
      tr = tr - rad;
      for (int dx = 0; dx < k; dx++) begin
        tc = col_out + dx;
        if (tc < rad || tc - rad >= w) continue;
        tc = tc - rad;
        sum += line_mem[(tr * w + tc) % STORE_DEPTH];
      end
    end
    last = (row_out * w + col_out + 1 >= total);
    rw.blurred_value = 8'((sum / (k * k)) & 8'hff);
    rw.frame_end = last;
    if (last) begin
      row_in = 0; col_in = 0; row_out = 0; col_out = 0;
    end else begin
      col_out++;
      if (col_out >= w) begin
        col_out = 0;
        row_out++;
      end
    end
    return 1;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic push_word(input logic cmd, input logic [7:0] pv);
    pix_word_t wd;
    wd.command = cmd;
    wd.pixel_value = pv;
    pending_q = {pending_q, wd};
    items_added++;
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || pix.valid || blur_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [DIM_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    blur_config(idx, val);
  endtask

  // style: 0 clean, 1 noisy, 2 cut short, 3 extreme pixel values
  task automatic run_frame(input int w, input int h, input int k, input int style);
    int unsigned n, lag, ew, ek;
    logic [7:0] v;
    wait_idle();
    cfg_write(REG_WIDTH, DIM_W'(w));
    cfg_write(REG_HEIGHT, DIM_W'(h));
    cfg_write(REG_KERNEL, DIM_W'(k));
    if ($urandom_range(3) == 0) cfg_write(REG_UNUSED, DIM_W'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
    ew = eff_w(); ek = eff_k();
    n = ew * eff_h();
    lag = ((ek - 1) / 2) * ew + (ek - 1) / 2;
    if (style == 2) n = $urandom_range(n);
    for (int unsigned i = 0; i < n; i++) begin
      if (style == 1 && $urandom_range(7) == 0) push_word(CMD_FLUSH, 8'($urandom));
      v = (style == 3) ? ((i % 2) ? 8'hff : 8'h00) : 8'($urandom);
      push_word(~CMD_FLUSH, v);
    end
    if (style != 2) begin
      for (int unsigned i = 0; i < lag; i++) begin
        if (style == 1 && $urandom_range(3) == 0) push_word(~CMD_FLUSH, 8'($urandom));
        else push_word(CMD_FLUSH, 8'($urandom));
      end
    end
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
    end else if (!pix.valid || in_took) begin
      if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
        pix.valid <= 1'b1;
        {pix.command, pix.pixel_value} <= pending_q.pop_front();
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_gen != hold_seen) begin
      hold_seen = hold_gen;
      hold_cnt = 600;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= calm || ($urandom_range(99) >= 16);
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    pix_word_t  wd;
    blur_word_t pred, want;
    took = 1'b0;
    in_took = 1'b0;
    if (!rst) begin
      if (pix.valid && pix.ready) begin
        took = 1'b1;
        in_took = 1'b1;
        wd = {pix.command, pix.pixel_value};
        if (blur_step(wd, pred)) blur_q = {blur_q, pred};
      end
      if (res.valid && res.ready) begin
        took = 1'b1;
        if (blur_q.size() == 0) begin
          report("unexpected word", res.blurred_value, -1);
        end else begin
          want = blur_q.pop_front();
          if (res.blurred_value !== want.blurred_value)
            report("blurred_value", res.blurred_value, want.blurred_value);
          if (res.frame_end !== want.frame_end)
            report("frame_end", res.frame_end, want.frame_end);
        end
      end
      if (took || cfg_we) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("tb_box_blur_filter_unit: FAIL");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix.valid = 1'b0;
    pix.command = 1'b0;
    pix.pixel_value = '0;
    res.ready = 1'b0;
    errors = 0;
    items_added = 0;
    calm = 1'b0;
    hold_gen = 0;
    hold_seen = 0;
    hold_cnt = 0;
    took = 1'b0;
    in_took = 1'b0;
    quiet = 0;
    for (int i = 0; i < STORE_DEPTH; i++) line_mem[i] = '0;
    row_in = 0; col_in = 0; row_out = 0; col_out = 0;
    reg_w = 640; reg_h = 480; reg_k = 3;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed
    run_frame(4, 3, 3, 3);
    run_frame(1, 1, 7, 0);
    run_frame(0, 0, 0, 0);
    run_frame(5, 4, 4, 1);
    run_frame(7, 7, 7, 3);
    run_frame(3, 2, 6, 1);
    run_frame(6, 5, 2, 2);
    run_frame(4, 4, 5, 1);

    // random
    while (items_added < 1750) begin
      calm = (items_added > 500 && items_added < 800);
      if (items_added > 1000 && hold_gen == 0) begin
        run_frame(12, 6, 3, 0);
        hold_gen = 1;
      end else begin
        case ($urandom_range(9))
          0: run_frame($urandom_range(12), $urandom_range(6), $urandom_range(7), 1);
          1: run_frame($urandom_range(12), $urandom_range(6), $urandom_range(7), 2);
          default: run_frame($urandom_range(1, 12), $urandom_range(1, 6),
                             $urandom_range(7), 0);
        endcase
      end
    end
    calm = 1'b0;
    wait_idle();
    if (errors == 0) begin
      $display("tb_box_blur_filter_unit: PASS");
    end else begin
      $display("tb_box_blur_filter_unit: FAIL");
    end
    $finish;
  end

endmodule
